@@ sv/frmdec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frmdec_pkg
// Shared types, codes and the CRC-32 byte step for the frame decoder.
// ----------------------------------------------------------------------------
package frmdec_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned CRC_BYTES    = 12;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES32   = 32'hFFFF_FFFF;
  localparam logic [32:0] COUNT_MAX    = 33'h1_FFFF_FFFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_TYPE      = 3'd4,
    ST_OVERSIZED = 3'd5,
    ST_CRC       = 3'd6,
    ST_TRAILING  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    REG_MAGIC        = 2'd0,
    REG_VERSION      = 2'd1,
    REG_HIGHEST_TYPE = 2'd2,
    REG_MAX_PAYLOAD  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] frame_type;
    logic [31:0] payload_length;
    logic [32:0] consumed;
    logic        final_item;
  } out_item_t;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [15:0] frame_version;
    logic [15:0] highest_type;
    logic [31:0] max_payload;
  } cfg_t;

  // results produced by one request, in delivery order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/frame_decoder_crc32_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_decoder_crc32_check
// Length-prefixed frame decoder with header checks and CRC-32 verification.
// Throughput: one request per cycle while in_ready is high; the end request of a
//   frame can add a second result, and the QUEUE_DEPTH result queue absorbs it
//   (out drains 1/cycle while out_ready is high); results are registered in
//   the queue. in_ready is high while the queue has room for two results.
// Reset: synchronous, clears counters, CRC and queue; no clearing pass.
// ----------------------------------------------------------------------------
module frame_decoder_crc32_check #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire frmdec_pkg::in_item_t    in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output frmdec_pkg::out_item_t        out_data,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [3:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import frmdec_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  in_fire;

  assign in_fire = in_valid && in_ready;

  frmdec_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frmdec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_fire (in_fire),
    .in_item (in_data),
    .push    (push)
  );

  frmdec_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/frmdec_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frmdec_cfg
// APB register file: magic, version, highest type and payload limit.
// ----------------------------------------------------------------------------
module frmdec_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output frmdec_pkg::cfg_t        cfg
);
  import frmdec_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_magic   <= 32'd0;
      cfg_r.frame_version <= 16'd1;
      cfg_r.highest_type  <= 16'd23;
      cfg_r.max_payload   <= 32'd1048576;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAGIC:        cfg_r.frame_magic   <= pwdata;
        REG_VERSION:      cfg_r.frame_version <= pwdata[15:0];
        REG_HIGHEST_TYPE: cfg_r.highest_type  <= pwdata[15:0];
        REG_MAX_PAYLOAD:  cfg_r.max_payload   <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC:        prdata = cfg_r.frame_magic;
      REG_VERSION:      prdata = {16'd0, cfg_r.frame_version};
      REG_HIGHEST_TYPE: prdata = {16'd0, cfg_r.highest_type};
      REG_MAX_PAYLOAD:  prdata = cfg_r.max_payload;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/frmdec_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frmdec_core
// Header capture and check, running CRC, payload pass-through, end status.
// ----------------------------------------------------------------------------
module frmdec_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire frmdec_pkg::cfg_t   cfg,
  input  wire logic               in_fire,
  input  wire frmdec_pkg::in_item_t in_item,
  output frmdec_pkg::push_t       push
);
  import frmdec_pkg::*;

  logic [32:0] byte_count_r, byte_count_nxt;
  logic [31:0] crc_r, crc_nxt;
  status_t     hdr_err_r, hdr_err_nxt;
  logic [7:0]  hdr_r [HEADER_BYTES];

  logic        has, fin;
  logic        in_hdr, hdr_last, take_payload, crc_feed;
  logic [31:0] magic, len, chk, crc_now;
  logic [15:0] version, ftype;
  logic [32:0] total, cnt_now;
  status_t     hdr_check, err_now, st;
  out_item_t   pay_item, stat_item;

  assign has      = in_item.has_byte;
  assign fin      = in_item.buffer_end;
  assign in_hdr   = byte_count_r < 33'(HEADER_BYTES);
  assign hdr_last = byte_count_r == 33'(HEADER_BYTES - 1);

  assign magic   = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3]};
  assign version = {hdr_r[4], hdr_r[5]};
  assign ftype   = {hdr_r[6], hdr_r[7]};
  assign len     = {hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11]};
  // last checksum byte may arrive with the end marker
  assign chk     = {hdr_r[12], hdr_r[13], hdr_r[14],
                    (has && hdr_last) ? in_item.data_byte : hdr_r[15]};
  assign total   = 33'(HEADER_BYTES) + {1'b0, len};

  always_comb begin
    priority if (magic != cfg.frame_magic)                  hdr_check = ST_MAGIC;
    else if (version != cfg.frame_version)                  hdr_check = ST_VERSION;
    else if (ftype == 16'd0 || ftype > cfg.highest_type)    hdr_check = ST_TYPE;
    else if (len > cfg.max_payload)                         hdr_check = ST_OVERSIZED;
    else                                                    hdr_check = ST_OK;
  end

  assign take_payload = has && !in_hdr && (hdr_err_r == ST_OK) && (byte_count_r < total);
  assign crc_feed     = (has && byte_count_r < 33'(CRC_BYTES)) || take_payload;
  assign crc_now      = crc_feed ? crc_byte(crc_r, in_item.data_byte) : crc_r;
  assign cnt_now      = (has && byte_count_r != COUNT_MAX) ? byte_count_r + 33'd1
                                                           : byte_count_r;
  assign err_now      = (has && hdr_last) ? hdr_check : hdr_err_r;

  always_comb begin
    stat_item              = '0;
    stat_item.item_kind    = KIND_STATUS;
    stat_item.final_item   = 1'b1;
    if (cnt_now < 33'(HEADER_BYTES)) begin
      st = ST_TRUNCATED;
    end else begin
      stat_item.payload_length = len;
      priority if (err_now != ST_OK)          st = err_now;
      else if (cnt_now < total)               st = ST_TRUNCATED;
      else if ((crc_now ^ ALL_ONES32) != chk) st = ST_CRC;
      else begin
        st = (cnt_now != total) ? ST_TRAILING : ST_OK;
        stat_item.frame_type = ftype;
        stat_item.consumed   = total;
      end
    end
    stat_item.status = st;
  end

  always_comb begin
    pay_item              = '0;
    pay_item.item_kind    = KIND_PAYLOAD;
    pay_item.payload_byte = in_item.data_byte;
  end

  always_comb begin
    push.count  = in_fire ? ({1'b0, take_payload} + {1'b0, fin}) : 2'd0;
    push.first  = take_payload ? pay_item : stat_item;
    push.second = stat_item;
  end

  always_comb begin
    byte_count_nxt = cnt_now;
    crc_nxt        = crc_now;
    hdr_err_nxt    = err_now;
    if (fin) begin
      byte_count_nxt = '0;
      crc_nxt        = ALL_ONES32;
      hdr_err_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= ALL_ONES32;
      hdr_err_r    <= ST_OK;
    end else if (in_fire) begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      hdr_err_r    <= hdr_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has && in_hdr) begin
      hdr_r[byte_count_r[3:0]] <= in_item.data_byte;
    end
  end

endmodule
`default_nettype wire

@@ sv/frmdec_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frmdec_outq
// Result queue: takes up to two results per cycle, delivers one per cycle on out_ready.
// ----------------------------------------------------------------------------
module frmdec_outq #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire frmdec_pkg::push_t    push,
  output logic                      space_ok,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output frmdec_pkg::out_item_t     out_data
);
  import frmdec_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = PW + 1;

  out_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = count_r <= CW'(DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.second;
    end
  end

endmodule
`default_nettype wire

@@ sv/frmdec_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frmdec_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module frmdec_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire frmdec_pkg::out_item_t out_data
);
  import frmdec_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_STATUS |-> out_data.final_item)
    else $error("status item not marked final");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_PAYLOAD |->
      !out_data.final_item && out_data.status == ST_OK && out_data.consumed == '0)
    else $error("payload item carries status fields");

  a_consumed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_STATUS &&
      out_data.status != ST_OK && out_data.status != ST_TRAILING |->
      out_data.consumed == '0 && out_data.frame_type == '0)
    else $error("failed frame reports consumed bytes");

endmodule

bind frame_decoder_crc32_check frmdec_checker u_frmdec_checker (.*);
`default_nettype wire
